### hw/rtl/assert_macros.svh
// Assertion macros used by the grid atlas allocator controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define GAA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gaa assertion failed");

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define GAA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gaa assertion failed");

`endif

### hw/rtl/gaa_pkg.sv
// Shared constants, types and a helper function of the grid atlas allocator.
package gaa_pkg;

    localparam int MAX_COLS   = 64;
    localparam int MAX_ROWS   = 64;
    localparam int COL_IDX_W  = $clog2(MAX_COLS);
    localparam int COL_CNT_W  = COL_IDX_W + 1;
    localparam int ROW_IDX_W  = $clog2(MAX_ROWS);
    localparam int ROW_CNT_W  = ROW_IDX_W + 1;
    localparam int DIM_W      = 7;
    localparam int PORT_W     = 11;
    localparam int PIX_W      = 17;
    localparam int POS_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int PROD_W     = 2 * PIX_W;
    localparam int TOT_W      = 33;
    localparam int ACC_W      = 29;
    localparam int SCORE_W    = 38;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PORTION_WIDTH  = 2'd0,
        CFG_PORTION_HEIGHT = 2'd1,
        CFG_GRID_COLS      = 2'd2,
        CFG_GRID_ROWS      = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        DIV_X,
        DIV_Y,
        DIV_W,
        DIV_H
    } div_src_t;

    typedef enum logic [2:0] {
        MUL_GW,
        MUL_GH,
        MUL_TOT,
        MUL_XP,
        MUL_YP,
        MUL_RP,
        MUL_BP
    } mul_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD
    } acc_op_t;

    typedef struct packed {
        logic     load_req;
        logic     div_start;
        div_src_t div_src;
        mul_sel_t mul_sel;
        logic     gw_ld;
        logic     gh_ld;
        logic     tot_ld;
        logic     scan_init;
        logic     row_start;
        logic     or_acc;
        logic     col_init;
        logic     col_next;
        logic     row_next;
        acc_op_t  acc_op;
        logic     ntot_ld;
        logic     score_ld;
        logic     best_upd;
        logic     mark_init;
        logic     clr_init;
        logic     mem_wr;
        logic     halve;
        logic     res_ld;
        logic     res_ok;
    } gaa_cmd_t;

    typedef struct packed {
        logic kind;
        logic div_done;
        logic pre_fail;
        logic row_fits;
        logic col_fits;
        logic win_free;
        logic row_last;
        logic found;
        logic retry_ok;
        logic da_ok;
    } gaa_sts_t;

    // Ones in bit positions start .. start+count-1, nothing past the top bit.
    function automatic logic [MAX_COLS-1:0] span_mask(input logic [COL_IDX_W-1:0] start,
                                                     input logic [COL_CNT_W-1:0] count);
        logic [COL_CNT_W:0]  lo;
        logic [COL_CNT_W:0]  hi;
        logic [MAX_COLS-1:0] m;
        lo = (COL_CNT_W + 1)'(start);
        hi = lo + (COL_CNT_W + 1)'(count);
        for (int b = 0; b < MAX_COLS; b++)
        begin
            m[b] = ((COL_CNT_W + 1)'(b) >= lo) && ((COL_CNT_W + 1)'(b) < hi);
        end
        return m;
    endfunction

endpackage

### hw/rtl/gaa_req_if.sv
// Request channel: valid/ready handshake with the allocate and release fields.
interface gaa_req_if;
    import gaa_pkg::*;

    logic             valid;
    logic             ready;
    logic             kind;
    logic [PIX_W-1:0] req_width;
    logic [PIX_W-1:0] req_height;
    logic             downscale_on_fail;
    logic [POS_W-1:0] free_x;
    logic [POS_W-1:0] free_y;
    logic [PIX_W-1:0] free_width;
    logic [PIX_W-1:0] free_height;

    modport source (
        output valid, kind, req_width, req_height, downscale_on_fail,
               free_x, free_y, free_width, free_height,
        input  ready
    );

    modport sink (
        input  valid, kind, req_width, req_height, downscale_on_fail,
               free_x, free_y, free_width, free_height,
        output ready
    );
endinterface

### hw/rtl/gaa_res_if.sv
// Result channel: valid/ready handshake with the granted position and size.
interface gaa_res_if;
    import gaa_pkg::*;

    logic             valid;
    logic             ready;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [PIX_W-1:0] granted_width;
    logic [PIX_W-1:0] granted_height;
    logic             granted;

    modport source (
        output valid, pos_x, pos_y, granted_width, granted_height, granted,
        input  ready
    );

    modport sink (
        input  valid, pos_x, pos_y, granted_width, granted_height, granted,
        output ready
    );
endinterface

### hw/rtl/grid_atlas_allocator_unit.sv
// Grid atlas allocator: handles one request at a time. Each request first runs two (allocate)
// or four (release) serial divisions. An allocate attempt then sets up the grid geometry and,
// for every candidate row, ORs the window rows out of the used-map memory and then steps past
// each blocked column or scores each free column through the shared scoring multiplier; a grant
// then marks the window in the map. A downscaling request repeats the two size divisions and
// the attempt once per halving. A release clears its rows in a read-modify-write pass.
// The result is held in an output register, so a new request is taken while it waits.
module grid_atlas_allocator_unit
    import gaa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    gaa_req_if.sink               request,
    gaa_res_if.source             result
);
    gaa_cmd_t cmd;
    gaa_sts_t sts;

    gaa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (request.valid),
        .req_kind  (request.kind),
        .req_ready (request.ready),
        .res_valid (result.valid),
        .res_ready (result.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    gaa_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .req_kind        (request.kind),
        .req_width       (request.req_width),
        .req_height      (request.req_height),
        .req_downscale   (request.downscale_on_fail),
        .req_free_x      (request.free_x),
        .req_free_y      (request.free_y),
        .req_free_width  (request.free_width),
        .req_free_height (request.free_height),
        .cmd             (cmd),
        .sts             (sts),
        .pos_x           (result.pos_x),
        .pos_y           (result.pos_y),
        .granted_width   (result.granted_width),
        .granted_height  (result.granted_height),
        .granted         (result.granted)
    );
endmodule

### hw/rtl/gaa_div.sv
// Restoring divider that produces one quotient bit per cycle.
module gaa_div
    import gaa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [PIX_W-1:0]  dividend,
    input  logic [PORT_W-1:0] divisor,
    output logic              done,
    output logic [PIX_W-1:0]  quotient
);
    localparam int CNT_W = $clog2(PIX_W + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [PIX_W-1:0]  q_reg;
    logic [PORT_W-1:0] rem_reg;
    logic [PORT_W:0]   shifted;
    logic [PORT_W:0]   diff;
    logic              take;

    assign shifted = {rem_reg, q_reg[PIX_W-1]};
    assign diff    = shifted - {1'b0, divisor};
    assign take    = shifted >= {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(PIX_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            q_reg   <= {q_reg[PIX_W-2:0], take};
            rem_reg <= take ? diff[PORT_W-1:0] : shifted[PORT_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;
endmodule

### hw/rtl/gaa_dp.sv
// Datapath: configuration, request fields, used map, divider, multiplier and scoring.
module gaa_dp
    import gaa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  req_kind,
    input  logic [PIX_W-1:0]      req_width,
    input  logic [PIX_W-1:0]      req_height,
    input  logic                  req_downscale,
    input  logic [POS_W-1:0]      req_free_x,
    input  logic [POS_W-1:0]      req_free_y,
    input  logic [PIX_W-1:0]      req_free_width,
    input  logic [PIX_W-1:0]      req_free_height,
    input  gaa_cmd_t              cmd,
    output gaa_sts_t              sts,
    output logic [POS_W-1:0]      pos_x,
    output logic [POS_W-1:0]      pos_y,
    output logic [PIX_W-1:0]      granted_width,
    output logic [PIX_W-1:0]      granted_height,
    output logic                  granted
);
    // Configuration registers and their effective values.
    logic [PORT_W-1:0] pw_reg;
    logic [PORT_W-1:0] ph_reg;
    logic [DIM_W-1:0]  cols_reg;
    logic [DIM_W-1:0]  rows_reg;
    logic [PORT_W-1:0] pw_e;
    logic [PORT_W-1:0] ph_e;
    logic [DIM_W-1:0]  cols_e;
    logic [DIM_W-1:0]  rows_e;

    // Request registers.
    logic              kind_reg;
    logic              down_reg;
    logic [PIX_W-1:0]  w_reg;
    logic [PIX_W-1:0]  h_reg;
    logic [POS_W-1:0]  fx_reg;
    logic [POS_W-1:0]  fy_reg;

    // Divider and quotients.
    div_src_t          src_reg;
    logic [PIX_W-1:0]  dvd;
    logic [PORT_W-1:0] dvs;
    logic              div_done;
    logic [PIX_W-1:0]  div_q;
    logic [PIX_W-1:0]  qx_reg;
    logic [PIX_W-1:0]  qy_reg;
    logic [PIX_W-1:0]  qw_reg;
    logic [PIX_W-1:0]  qh_reg;
    logic [COL_CNT_W-1:0] nx;
    logic [ROW_CNT_W-1:0] ny;

    // Geometry and scoring.
    logic [PIX_W-1:0]  mul_a;
    logic [PIX_W-1:0]  mul_b;
    logic [PROD_W-1:0] prod_reg;
    logic [PIX_W-1:0]  gw_reg;
    logic [PIX_W-1:0]  gh_reg;
    logic [TOT_W-1:0]  tot_reg;
    logic [ROW_CNT_W-1:0] i_reg;
    logic [COL_CNT_W-1:0] j_reg;
    logic [PIX_W-1:0]  x_reg;
    logic [PIX_W-1:0]  y_reg;
    logic signed [PIX_W+1:0] rt;
    logic signed [PIX_W+1:0] bt;
    logic [PIX_W-1:0]  rt_pos;
    logic [PIX_W-1:0]  bt_pos;
    logic [2:0]        n_sides;
    logic [SCORE_W-1:0] ntot_next;
    logic [ACC_W-1:0]  acc_reg;
    logic [SCORE_W-1:0] ntot_reg;
    logic [SCORE_W-1:0] score_reg;
    logic [SCORE_W-1:0] best_reg;
    logic              found_reg;
    logic [ROW_IDX_W-1:0] bi_reg;
    logic [COL_IDX_W-1:0] bj_reg;
    logic [PIX_W-1:0]  bx_reg;
    logic [PIX_W-1:0]  by_reg;
    logic [MAX_COLS-1:0] nmask_reg;
    logic [MAX_COLS-1:0] orv_reg;

    // Used map and row walker.
    logic [MAX_COLS-1:0] mem [MAX_ROWS];
    logic [MAX_ROWS-1:0] vld_reg;
    logic [MAX_COLS-1:0] mem_q_reg;
    logic                vld_q_reg;
    logic [MAX_COLS-1:0] rd_word;
    logic [ROW_CNT_W-1:0] row_ptr_reg;
    logic [ROW_CNT_W-1:0] row_end_reg;
    logic [MAX_COLS-1:0] wmask_reg;
    logic                set_reg;

    // Release clipping.
    logic [DIM_W-1:0]  cols_left;
    logic [DIM_W-1:0]  rows_left;
    logic [DIM_W-1:0]  cend;
    logic [DIM_W-1:0]  rend;

    // Result registers.
    logic [POS_W-1:0]  pos_x_reg;
    logic [POS_W-1:0]  pos_y_reg;
    logic [PIX_W-1:0]  gw_out_reg;
    logic [PIX_W-1:0]  gh_out_reg;
    logic              granted_reg;

    assign pw_e = (pw_reg == '0) ? PORT_W'(1) : pw_reg;
    assign ph_e = (ph_reg == '0) ? PORT_W'(1) : ph_reg;

    always_comb
    begin
        if (cols_reg == '0)
            cols_e = DIM_W'(1);
        else if (cols_reg > DIM_W'(MAX_COLS))
            cols_e = DIM_W'(MAX_COLS);
        else
            cols_e = cols_reg;
        if (rows_reg == '0)
            rows_e = DIM_W'(1);
        else if (rows_reg > DIM_W'(MAX_ROWS))
            rows_e = DIM_W'(MAX_ROWS);
        else
            rows_e = rows_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pw_reg   <= PORT_W'(64);
            ph_reg   <= PORT_W'(64);
            cols_reg <= DIM_W'(64);
            rows_reg <= DIM_W'(64);
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_PORTION_WIDTH:  pw_reg   <= cfg_data;
                CFG_PORTION_HEIGHT: ph_reg   <= cfg_data;
                CFG_GRID_COLS:      cols_reg <= cfg_data[DIM_W-1:0];
                CFG_GRID_ROWS:      rows_reg <= cfg_data[DIM_W-1:0];
                default:            ;
            endcase
        end
    end

    // Request capture; a release keeps its size in the same registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            kind_reg <= req_kind;
            down_reg <= req_downscale;
            w_reg    <= req_kind ? req_free_width : req_width;
            h_reg    <= req_kind ? req_free_height : req_height;
            fx_reg   <= req_free_x;
            fy_reg   <= req_free_y;
        end
        else if (cmd.halve)
        begin
            w_reg <= w_reg >> 1;
            h_reg <= h_reg >> 1;
        end
    end

    always_comb
    begin
        unique case (cmd.div_src)
            DIV_X:   begin dvd = {1'b0, fx_reg}; dvs = pw_e; end
            DIV_Y:   begin dvd = {1'b0, fy_reg}; dvs = ph_e; end
            DIV_W:   begin dvd = w_reg;          dvs = pw_e; end
            DIV_H:   begin dvd = h_reg;          dvs = ph_e; end
            default: begin dvd = w_reg;          dvs = pw_e; end
        endcase
    end

    gaa_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dvd),
        .divisor  (dvs),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
            src_reg <= cmd.div_src;
        if (div_done)
        begin
            unique case (src_reg)
                DIV_X:   qx_reg <= div_q;
                DIV_Y:   qy_reg <= div_q;
                DIV_W:   qw_reg <= div_q;
                DIV_H:   qh_reg <= div_q;
                default: qw_reg <= div_q;
            endcase
        end
    end

    // Window size in portions; only used once it is known to fit the grid.
    assign nx = qw_reg[COL_CNT_W-1:0];
    assign ny = qh_reg[ROW_CNT_W-1:0];

    // One shared multiplier with a registered product.
    always_comb
    begin
        unique case (cmd.mul_sel)
            MUL_GW:  begin mul_a = PIX_W'(cols_e); mul_b = PIX_W'(pw_e); end
            MUL_GH:  begin mul_a = PIX_W'(rows_e); mul_b = PIX_W'(ph_e); end
            MUL_TOT: begin mul_a = gw_reg;         mul_b = gh_reg;       end
            MUL_XP:  begin mul_a = x_reg;          mul_b = PIX_W'(ph_e); end
            MUL_YP:  begin mul_a = y_reg;          mul_b = PIX_W'(pw_e); end
            MUL_RP:  begin mul_a = rt_pos;         mul_b = PIX_W'(ph_e); end
            MUL_BP:  begin mul_a = bt_pos;         mul_b = PIX_W'(pw_e); end
            default: begin mul_a = x_reg;          mul_b = PIX_W'(ph_e); end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    // Distances to the right and bottom edges may be negative by less than a portion.
    assign rt = $signed({2'b00, gw_reg}) - $signed({2'b00, x_reg}) - $signed({2'b00, w_reg});
    assign bt = $signed({2'b00, gh_reg}) - $signed({2'b00, y_reg}) - $signed({2'b00, h_reg});
    assign rt_pos = (rt > 0) ? rt[PIX_W-1:0] : '0;
    assign bt_pos = (bt > 0) ? bt[PIX_W-1:0] : '0;
    assign n_sides = 3'((x_reg != '0)) + 3'((y_reg != '0)) + 3'((rt > 0)) + 3'((bt > 0));

    always_comb
    begin
        ntot_next = (n_sides[0] ? SCORE_W'(tot_reg) : '0)
                  + (n_sides[1] ? (SCORE_W'(tot_reg) << 1) : '0)
                  + (n_sides[2] ? (SCORE_W'(tot_reg) << 2) : '0);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.gw_ld)
            gw_reg <= prod_reg[PIX_W-1:0];
        if (cmd.gh_ld)
            gh_reg <= prod_reg[PIX_W-1:0];
        if (cmd.tot_ld)
            tot_reg <= prod_reg[TOT_W-1:0];
        unique case (cmd.acc_op)
            ACC_LOAD: acc_reg <= prod_reg[ACC_W-1:0];
            ACC_ADD:  acc_reg <= acc_reg + prod_reg[ACC_W-1:0];
            default:  ;
        endcase
        if (cmd.ntot_ld)
            ntot_reg <= ntot_next << 1;
        if (cmd.score_ld)
            score_reg <= ntot_reg + SCORE_W'(acc_reg) + (SCORE_W'(acc_reg) << 1);
    end

    // Scan position counters and the best candidate so far.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            found_reg <= 1'b0;
        else if (cmd.scan_init)
            found_reg <= 1'b0;
        else if (cmd.best_upd)
            found_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_init)
        begin
            i_reg     <= '0;
            y_reg     <= '0;
            nmask_reg <= span_mask('0, nx);
        end
        else if (cmd.row_next)
        begin
            i_reg <= i_reg + ROW_CNT_W'(1);
            y_reg <= y_reg + PIX_W'(ph_e);
        end
        if (cmd.col_init)
        begin
            j_reg <= '0;
            x_reg <= '0;
        end
        else if (cmd.col_next)
        begin
            j_reg <= j_reg + COL_CNT_W'(1);
            x_reg <= x_reg + PIX_W'(pw_e);
        end
        if (cmd.best_upd && (!found_reg || (score_reg < best_reg)))
        begin
            best_reg <= score_reg;
            bi_reg   <= i_reg[ROW_IDX_W-1:0];
            bj_reg   <= j_reg[COL_IDX_W-1:0];
            bx_reg   <= x_reg;
            by_reg   <= y_reg;
        end
    end

    // Release region, clipped to the grid in use.
    assign cols_left = cols_e - qx_reg[DIM_W-1:0];
    assign rows_left = rows_e - qy_reg[DIM_W-1:0];
    assign cend = (qw_reg > PIX_W'(cols_left)) ? cols_e : (qx_reg[DIM_W-1:0] + qw_reg[DIM_W-1:0]);
    assign rend = (qh_reg > PIX_W'(rows_left)) ? rows_e : (qy_reg[DIM_W-1:0] + qh_reg[DIM_W-1:0]);

    // Row walker shared by the window OR pass and the read-modify-write pass.
    always_ff @(posedge clk)
    begin
        if (cmd.row_start)
        begin
            row_ptr_reg <= i_reg;
            row_end_reg <= i_reg + ny;
            orv_reg     <= '0;
        end
        else if (cmd.mark_init)
        begin
            row_ptr_reg <= ROW_CNT_W'(bi_reg);
            row_end_reg <= ROW_CNT_W'(bi_reg) + ny;
            wmask_reg   <= span_mask(bj_reg, nx);
            set_reg     <= 1'b1;
        end
        else if (cmd.clr_init)
        begin
            row_ptr_reg <= qy_reg[ROW_CNT_W-1:0];
            row_end_reg <= ROW_CNT_W'(rend);
            wmask_reg   <= span_mask(qx_reg[COL_IDX_W-1:0],
                                     COL_CNT_W'(cend - qx_reg[DIM_W-1:0]));
            set_reg     <= 1'b0;
        end
        else if (cmd.or_acc)
        begin
            orv_reg     <= orv_reg | rd_word;
            row_ptr_reg <= row_ptr_reg + ROW_CNT_W'(1);
        end
        else if (cmd.mem_wr)
        begin
            row_ptr_reg <= row_ptr_reg + ROW_CNT_W'(1);
        end
    end

    // Used map: rows never written read as free.
    always_ff @(posedge clk)
    begin
        mem_q_reg <= mem[row_ptr_reg[ROW_IDX_W-1:0]];
        if (cmd.mem_wr)
            mem[row_ptr_reg[ROW_IDX_W-1:0]] <= set_reg ? (rd_word | wmask_reg)
                                                        : (rd_word & ~wmask_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            vld_q_reg <= 1'b0;
        end
        else
        begin
            vld_q_reg <= vld_reg[row_ptr_reg[ROW_IDX_W-1:0]];
            if (cmd.mem_wr)
                vld_reg[row_ptr_reg[ROW_IDX_W-1:0]] <= 1'b1;
        end
    end

    assign rd_word = vld_q_reg ? mem_q_reg : '0;

    always_ff @(posedge clk)
    begin
        if (cmd.res_ld)
        begin
            pos_x_reg   <= cmd.res_ok ? bx_reg[POS_W-1:0] : '0;
            pos_y_reg   <= cmd.res_ok ? by_reg[POS_W-1:0] : '0;
            gw_out_reg  <= cmd.res_ok ? w_reg : '0;
            gh_out_reg  <= cmd.res_ok ? h_reg : '0;
            granted_reg <= cmd.res_ok;
        end
    end

    assign pos_x          = pos_x_reg;
    assign pos_y          = pos_y_reg;
    assign granted_width  = gw_out_reg;
    assign granted_height = gh_out_reg;
    assign granted        = granted_reg;

    always_comb
    begin
        sts.kind     = kind_reg;
        sts.div_done = div_done;
        sts.pre_fail = (qw_reg == '0) || (qh_reg == '0)
                    || (qw_reg > PIX_W'(cols_e)) || (qh_reg > PIX_W'(rows_e));
        sts.row_fits = ((ROW_CNT_W + 1)'(i_reg) + (ROW_CNT_W + 1)'(ny))
                    <= (ROW_CNT_W + 1)'(rows_e);
        sts.col_fits = ((COL_CNT_W + 1)'(j_reg) + (COL_CNT_W + 1)'(nx))
                    <= (COL_CNT_W + 1)'(cols_e);
        sts.win_free = ((orv_reg >> j_reg[COL_IDX_W-1:0]) & nmask_reg) == '0;
        sts.row_last = (row_ptr_reg + ROW_CNT_W'(1)) == row_end_reg;
        sts.found    = found_reg;
        sts.retry_ok = down_reg && (qw_reg != '0) && (qh_reg != '0)
                    && !((w_reg == PIX_W'(pw_e)) && (h_reg == PIX_W'(ph_e)));
        sts.da_ok    = (qx_reg < PIX_W'(cols_e)) && (qy_reg < PIX_W'(rows_e))
                    && (qw_reg != '0) && (qh_reg != '0);
    end
endmodule

### hw/rtl/gaa_ctrl.sv
// Controller: sequences divisions, the placement scan, map updates and the result hand-off.
module gaa_ctrl
    import gaa_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    input  logic     req_kind,
    output logic     req_ready,
    output logic     res_valid,
    input  logic     res_ready,
    input  gaa_sts_t sts,
    output gaa_cmd_t cmd
);
`include "assert_macros.svh"

    typedef enum logic [4:0] {
        S_IDLE,
        S_DSTART,
        S_DWAIT,
        S_A_CHK,
        S_G0,
        S_G1,
        S_G2,
        S_G3,
        S_G4,
        S_ROW,
        S_OR_RD,
        S_OR_ACC,
        S_COL,
        S_SC0,
        S_SC1,
        S_SC2,
        S_SC3,
        S_SC4,
        S_SC5,
        S_SC6,
        S_END,
        S_A_FAIL,
        S_DA_CHK,
        S_RMW_RD,
        S_RMW_WR,
        S_RES
    } state_t;

    state_t   state_reg;
    div_src_t src_reg;
    logic     ok_reg;
    logic     out_vld_reg;
    logic     accept;
    logic     res_free;

    assign req_ready = (state_reg == S_IDLE);
    assign accept    = req_valid && req_ready;
    assign res_valid = out_vld_reg;
    assign res_free  = !out_vld_reg || res_ready;

    always_comb
    begin
        cmd         = '0;
        cmd.div_src = src_reg;
        cmd.mul_sel = MUL_GW;
        cmd.acc_op  = ACC_HOLD;
        cmd.res_ok  = ok_reg;
        unique case (state_reg)
            S_IDLE:   cmd.load_req = accept;
            S_DSTART: cmd.div_start = 1'b1;
            S_G0:     cmd.mul_sel = MUL_GW;
            S_G1:     begin cmd.mul_sel = MUL_GH; cmd.gw_ld = 1'b1; end
            S_G2:     cmd.gh_ld = 1'b1;
            S_G3:     cmd.mul_sel = MUL_TOT;
            S_G4:     begin cmd.tot_ld = 1'b1; cmd.scan_init = 1'b1; end
            S_ROW:    cmd.row_start = sts.row_fits;
            S_OR_ACC: begin cmd.or_acc = 1'b1; cmd.col_init = sts.row_last; end
            S_COL:
            begin
                cmd.row_next = !sts.col_fits;
                cmd.col_next = sts.col_fits && !sts.win_free;
            end
            S_SC0:    cmd.mul_sel = MUL_XP;
            S_SC1:    begin cmd.mul_sel = MUL_YP; cmd.acc_op = ACC_LOAD; end
            S_SC2:    begin cmd.mul_sel = MUL_RP; cmd.acc_op = ACC_ADD; end
            S_SC3:    begin cmd.mul_sel = MUL_BP; cmd.acc_op = ACC_ADD; end
            S_SC4:    begin cmd.acc_op = ACC_ADD; cmd.ntot_ld = 1'b1; end
            S_SC5:    cmd.score_ld = 1'b1;
            S_SC6:    begin cmd.best_upd = 1'b1; cmd.col_next = 1'b1; end
            S_END:    cmd.mark_init = sts.found;
            S_A_FAIL: begin cmd.halve = sts.retry_ok; cmd.div_src = DIV_W; end
            S_DA_CHK: cmd.clr_init = sts.da_ok;
            S_RMW_WR: cmd.mem_wr = 1'b1;
            S_RES:    cmd.res_ld = res_free;
            default:  ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            src_reg     <= DIV_W;
            ok_reg      <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if ((state_reg == S_RES) && res_free)
                out_vld_reg <= 1'b1;
            else if (out_vld_reg && res_ready)
                out_vld_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        src_reg   <= req_kind ? DIV_X : DIV_W;
                        state_reg <= S_DSTART;
                    end
                end
                S_DSTART: state_reg <= S_DWAIT;
                S_DWAIT:
                begin
                    if (sts.div_done)
                    begin
                        unique case (src_reg)
                            DIV_X:   begin src_reg <= DIV_Y; state_reg <= S_DSTART; end
                            DIV_Y:   begin src_reg <= DIV_W; state_reg <= S_DSTART; end
                            DIV_W:   begin src_reg <= DIV_H; state_reg <= S_DSTART; end
                            DIV_H:   state_reg <= sts.kind ? S_DA_CHK : S_A_CHK;
                            default: state_reg <= S_IDLE;
                        endcase
                    end
                end
                S_A_CHK:  state_reg <= sts.pre_fail ? S_A_FAIL : S_G0;
                S_G0:     state_reg <= S_G1;
                S_G1:     state_reg <= S_G2;
                S_G2:     state_reg <= S_G3;
                S_G3:     state_reg <= S_G4;
                S_G4:     state_reg <= S_ROW;
                S_ROW:    state_reg <= sts.row_fits ? S_OR_RD : S_END;
                S_OR_RD:  state_reg <= S_OR_ACC;
                S_OR_ACC: state_reg <= sts.row_last ? S_COL : S_OR_RD;
                S_COL:
                begin
                    if (!sts.col_fits)
                        state_reg <= S_ROW;
                    else if (sts.win_free)
                        state_reg <= S_SC0;
                end
                S_SC0:    state_reg <= S_SC1;
                S_SC1:    state_reg <= S_SC2;
                S_SC2:    state_reg <= S_SC3;
                S_SC3:    state_reg <= S_SC4;
                S_SC4:    state_reg <= S_SC5;
                S_SC5:    state_reg <= S_SC6;
                S_SC6:    state_reg <= S_COL;
                S_END:
                begin
                    ok_reg    <= sts.found;
                    state_reg <= sts.found ? S_RMW_RD : S_A_FAIL;
                end
                S_A_FAIL:
                begin
                    if (sts.retry_ok)
                    begin
                        src_reg   <= DIV_W;
                        state_reg <= S_DSTART;
                    end
                    else
                    begin
                        ok_reg    <= 1'b0;
                        state_reg <= S_RES;
                    end
                end
                S_DA_CHK:
                begin
                    ok_reg    <= 1'b0;
                    state_reg <= sts.da_ok ? S_RMW_RD : S_RES;
                end
                S_RMW_RD: state_reg <= S_RMW_WR;
                S_RMW_WR: state_reg <= sts.row_last ? S_RES : S_RMW_RD;
                S_RES:
                begin
                    if (res_free)
                        state_reg <= S_IDLE;
                end
                default:  state_reg <= S_IDLE;
            endcase
        end
    end

    // A new result never replaces one that the consumer has not taken.
    `GAA_ASSERT_IMP(a_res_no_overwrite, cmd.res_ld, !out_vld_reg || res_ready)
    // The result valid only rises after a result load.
    `GAA_ASSERT_IMP(a_valid_after_load, $rose(out_vld_reg), $past(cmd.res_ld))
    // An accepted request always starts a division sequence.
    `GAA_ASSERT_NXT(a_accept_starts, accept, state_reg == S_DSTART)
endmodule
